[src/grr_pkg.sv]
// ----------------------------------------------------------------------------
// grr_pkg
// Shared types, widths and constants for the group reverse reorder block.
// ----------------------------------------------------------------------------
package grr_pkg;

    // payload and register widths
    localparam int DATA_W        = 32;
    localparam int GS_W          = 5;
    localparam int MAX_GROUP_DEF = 16;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;

    // group size after reset
    localparam logic [GS_W-1:0] GS_RESET = GS_W'(4);

    // register word index (paddr bit 2 selects the word)
    localparam logic REG_GROUP_SIZE = 1'b0;

    typedef logic signed [DATA_W-1:0] value_t;

    // commands from controller to datapath
    typedef struct packed {
        logic take;   // input transfer: store element, update fill
        logic fetch;  // read the group store at the current position
        logic step;   // non-final result transfer, move to the next position
    } ctrl_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic emit;   // the offered element completes a run
        logic at_end; // current position is the last of the run
    } ctrl_status_t;

endpackage

[src/grr_in_if.sv]
// ----------------------------------------------------------------------------
// grr_in_if
// Input channel: one list element with its end-of-list flag.
// ----------------------------------------------------------------------------
interface grr_in_if
    import grr_pkg::*;
();

    logic   valid;
    logic   ready;
    value_t value;
    logic   list_end;

    modport source (output valid, output value, output list_end, input ready);
    modport sink   (input valid, input value, input list_end, output ready);

endinterface

[src/grr_out_if.sv]
// ----------------------------------------------------------------------------
// grr_out_if
// Output channel: one reordered element with run and list end flags.
// ----------------------------------------------------------------------------
interface grr_out_if
    import grr_pkg::*;
();

    logic   valid;
    logic   ready;
    value_t out_value;
    logic   run_last;
    logic   list_last;

    modport source (output valid, output out_value, output run_last, output list_last,
                    input ready);
    modport sink   (input valid, input out_value, input run_last, input list_last,
                    output ready);

endinterface

[src/grr_cfg.sv]
// ----------------------------------------------------------------------------
// grr_cfg
// APB register file holding the group size.
// ----------------------------------------------------------------------------
module grr_cfg
    import grr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [GS_W-1:0]    group_size
);

    logic [GS_W-1:0] group_size_reg;
    logic            wr_en;

    // access phase write strobe
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // group size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_size_reg <= GS_RESET;
        end
        else if (wr_en && (paddr[2] == REG_GROUP_SIZE))
        begin
            group_size_reg <= pwdata[GS_W-1:0];
        end
    end

    // read back
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_GROUP_SIZE)
        begin
            prdata = PDATA_W'(group_size_reg);
        end
    end

    assign group_size = group_size_reg;

endmodule

[src/grr_ctrl.sv]
// ----------------------------------------------------------------------------
// grr_ctrl
// Controller: takes elements, then steps through each run one result at a
// time, a fetch state followed by a show state per result.
// ----------------------------------------------------------------------------
module grr_ctrl
    import grr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_SHOW
    } state_t;

    state_t state_reg;

    // handshake outputs
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_SHOW);

    // commands to the datapath
    always_comb
    begin
        cmd.take  = in_valid && (state_reg == S_IDLE);
        cmd.fetch = (state_reg == S_FETCH);
        cmd.step  = (state_reg == S_SHOW) && out_ready && !status.at_end;
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && status.emit)
                    begin
                        state_reg <= S_FETCH;
                    end
                end
                S_FETCH:
                begin
                    state_reg <= S_SHOW;
                end
                S_SHOW:
                begin
                    if (out_ready)
                    begin
                        state_reg <= status.at_end ? S_IDLE : S_FETCH;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // never take an element while a result is on offer
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while a result is pending");

    // the last result of a run returns to idle
    a_run_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && status.at_end) |=> in_ready)
        else $error("not idle after the last result of a run");

    // an element that completes nothing leaves the block ready
    a_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take && !status.emit) |=> (in_ready && !out_valid))
        else $error("block busy after an element with no result");
`endif

endmodule

[src/grr_dpath.sv]
// ----------------------------------------------------------------------------
// grr_dpath
// Datapath: group store memory, fill count, run position and direction.
// ----------------------------------------------------------------------------
module grr_dpath
    import grr_pkg::*;
#(
    parameter int MAX_GROUP = MAX_GROUP_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [GS_W-1:0] group_size,
    input  value_t          value,
    input  logic            list_end,
    input  ctrl_cmd_t       cmd,
    output ctrl_status_t    status,
    output value_t          out_value,
    output logic            run_last,
    output logic            list_last
);

    localparam int IDX_W = $clog2(MAX_GROUP);
    localparam int CNT_W = $clog2(MAX_GROUP + 1);
    localparam int CMP_W = (CNT_W > GS_W) ? CNT_W : GS_W;

    value_t           mem [MAX_GROUP];
    value_t           rd_data_reg;
    logic [IDX_W-1:0] fill_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] last_pos_reg;
    logic             rev_reg;
    logic             lend_reg;

    logic [CNT_W-1:0] n;
    logic             full;
    logic [IDX_W-1:0] rd_addr;

    // count after storing the offered element, and group complete test
    assign n    = CNT_W'(fill_reg) + CNT_W'(1);
    assign full = (CMP_W'(n) >= CMP_W'(group_size)) || (n == CNT_W'(MAX_GROUP));

    assign status.emit   = full || list_end;
    assign status.at_end = (idx_reg == last_pos_reg);

    // full groups read backwards, short tails forwards
    assign rd_addr = rev_reg ? (last_pos_reg - idx_reg) : idx_reg;

    // group store, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            mem[fill_reg] <= value;
        end
        if (cmd.fetch)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // fill count and run bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            idx_reg      <= '0;
            last_pos_reg <= '0;
            rev_reg      <= 1'b0;
            lend_reg     <= 1'b0;
        end
        else if (cmd.take)
        begin
            if (status.emit)
            begin
                fill_reg     <= '0;
                idx_reg      <= '0;
                last_pos_reg <= fill_reg;
                rev_reg      <= full;
                lend_reg     <= list_end;
            end
            else
            begin
                fill_reg <= fill_reg + IDX_W'(1);
            end
        end
        else if (cmd.step)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    // result payload
    assign out_value = rd_data_reg;
    assign run_last  = status.at_end;
    assign list_last = status.at_end && lend_reg;

`ifndef SYNTHESIS
    // a completed run empties the store
    a_fill_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take && status.emit) |=> (fill_reg == '0))
        else $error("fill count not cleared after a run");

    // reads stay within the elements of the current run
    a_rd_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fetch |-> ((idx_reg <= last_pos_reg) && (rd_addr <= last_pos_reg)))
        else $error("group store read outside the run");

    // position never steps past the end of a run
    a_step_end: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (idx_reg != last_pos_reg))
        else $error("step beyond the last result");
`endif

endmodule

[src/group_reverse_reorder.sv]
// An input transfer that completes a run moves the controller to its fetch state, then
// to its show state, where the first result is offered. An element that completes no
// run leaves the input ready; one that completes a run holds the input until its last
// result is taken (a store read and a show per result, set by the store's one read port).
// Reset: control and fill count cleared, group size 4; the group store is not cleared.
// ----------------------------------------------------------------------------
// group_reverse_reorder
// Reverses list elements in configured-size groups; short list tails keep order.
// ----------------------------------------------------------------------------
module group_reverse_reorder
    import grr_pkg::*;
#(
    parameter int MAX_GROUP = MAX_GROUP_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    grr_in_if.sink             in_ch,
    grr_out_if.source          out_ch
);

    logic [GS_W-1:0] group_size;
    ctrl_cmd_t       cmd;
    ctrl_status_t    status;

    // configuration registers
    grr_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .group_size (group_size)
    );

    // sequencing
    grr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // storage and result payload
    grr_dpath #(
        .MAX_GROUP (MAX_GROUP)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .group_size (group_size),
        .value      (in_ch.value),
        .list_end   (in_ch.list_end),
        .cmd        (cmd),
        .status     (status),
        .out_value  (out_ch.out_value),
        .run_last   (out_ch.run_last),
        .list_last  (out_ch.list_last)
    );

endmodule

[verif/grr_checker.sv]
// ----------------------------------------------------------------------------
// grr_checker
// Watches the register port and both channels of the group reverse reorder
// block. It keeps its own copy of the group size, the group buffer and the
// fill count, predicts every reordered element from the input transfers and
// compares each output transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module grr_checker
    import grr_pkg::*;
#(
    parameter int MAX_GROUP = MAX_GROUP_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic               pready,
    grr_in_if                  in_ch,
    grr_out_if                 out_ch,
    output int                 errors,
    output int                 outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    // one reordered element as it should leave the block
    typedef struct packed {
        value_t out_value;
        logic   run_last;
        logic   list_last;
    } reordered_t;

    reordered_t      reordered_q[$];
    value_t          group_buf[MAX_GROUP];
    int unsigned     fill;
    logic [GS_W-1:0] group_size;

    // buffer one element and queue the run it completes, if any
    task automatic reorder_element(input value_t v, input logic last);
        int unsigned span;
        int unsigned n;
        reordered_t  r;
        span = (group_size > MAX_GROUP) ? MAX_GROUP : group_size;
        group_buf[fill] = v;
        fill++;
        n = fill;
        if (n >= span)
        begin
            // full group or pass through: newest element first
            for (int unsigned i = 0; i < n; i++)
            begin
                r.out_value = group_buf[n - 1 - i];
                r.run_last  = (i + 1 == n);
                r.list_last = (i + 1 == n) && last;
                reordered_q.push_back(r);
            end
            fill = 0;
        end
        else if (last)
        begin
            // short tail at the end of the list keeps its order
            for (int unsigned i = 0; i < n; i++)
            begin
                r.out_value = group_buf[i];
                r.run_last  = (i + 1 == n);
                r.list_last = (i + 1 == n);
                reordered_q.push_back(r);
            end
            fill = 0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        reordered_t want;
        if (!rst_n)
        begin
            fill        = 0;
            group_size  = GS_RESET;
            reordered_q.delete();
            outstanding = 0;
        end
        else
        begin
            // register write on the access phase
            if (psel && penable && pwrite && pready && paddr[2] == REG_GROUP_SIZE)
                group_size = pwdata[GS_W-1:0];

            // output transfer against the oldest prediction
            if (out_ch.valid && out_ch.ready)
            begin
                if (reordered_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: result %0d with nothing expected", $time,
                             out_ch.out_value);
                end
                else
                begin
                    want = reordered_q.pop_front();
                    if (out_ch.out_value !== want.out_value)
                    begin
                        errors++;
                        $display("%0t: out_value expected %0d actual %0d", $time,
                                 want.out_value, out_ch.out_value);
                    end
                    if (out_ch.run_last !== want.run_last)
                    begin
                        errors++;
                        $display("%0t: run_last expected %0b actual %0b", $time,
                                 want.run_last, out_ch.run_last);
                    end
                    if (out_ch.list_last !== want.list_last)
                    begin
                        errors++;
                        $display("%0t: list_last expected %0b actual %0b", $time,
                                 want.list_last, out_ch.list_last);
                    end
                end
            end

            // input transfer feeds the predictor
            if (in_ch.valid && in_ch.ready)
                reorder_element(in_ch.value, in_ch.list_end);

            outstanding = reordered_q.size();
        end
    end

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the group reverse reorder block. A short directed
// part covers extreme values, pass through, full and short groups at the end
// of a list and a group size lowered mid-group; random lists follow under a
// range of group sizes, with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench
    import grr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     STALL_LIMIT  = 2000;
    localparam int     RANDOM_ITEMS = 300;
    localparam int     SETTLE       = 8;
    localparam value_t VAL_MIN      = value_t'(32'h8000_0000);
    localparam value_t VAL_MAX      = value_t'(32'h7FFF_FFFF);

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               steady = 1'b0;
    int                 check_errors;
    int                 pending;
    int                 quiet_cycles = 0;

    grr_in_if  in_ch();
    grr_out_if out_ch();

    group_reverse_reorder dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    grr_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .errors      (check_errors),
        .outstanding (pending)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver back-pressure
    always @(negedge clk)
        out_ch.ready <= !rst_n ? 1'b0 :
                        (steady ? 1'b1 : ($urandom_range(99) >= 22));

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // offer one element, return at the falling edge after its transfer
    task automatic send_item(input value_t v, input logic last);
        while (!steady && $urandom_range(99) < 22)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.value    <= v;
        in_ch.list_end <= last;
        do
            @(posedge clk);
        while (!in_ch.ready);
        @(negedge clk);
    endtask

    // hold the sender until every result has left the block
    task automatic drain_block();
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // setup and access phase on the register port
    task automatic write_group_size(input logic [GS_W-1:0] gs);
        drain_block();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {REG_GROUP_SIZE, 2'b00};
        pwdata  <= PDATA_W'(gs);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // mostly random values with the extremes mixed in
    function automatic value_t pick_value();
        case ($urandom_range(9))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return value_t'(-1);
            3:       return value_t'(0);
            default: return value_t'($urandom);
        endcase
    endfunction

    function automatic logic [GS_W-1:0] pick_group_size(input int phase);
        case (phase)
            0:       return GS_W'(16);
            1:       return GS_W'(31);
            2:       return GS_W'(0);
            default:
                case ($urandom_range(7))
                    0:       return GS_W'(0);
                    1:       return GS_W'(1);
                    2:       return GS_W'(16);
                    3:       return GS_W'($urandom_range(17, 31));
                    default: return GS_W'($urandom_range(2, 15));
                endcase
        endcase
    endfunction

    initial
    begin
        int sent;
        int phase;
        int phase_len;
        int list_left;

        in_ch.valid    = 1'b0;
        in_ch.value    = '0;
        in_ch.list_end = 1'b0;
        sent      = 0;
        phase     = 0;
        list_left = 0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset group size of four, full group on the final element
        send_item(VAL_MIN, 1'b0);
        send_item(VAL_MAX, 1'b0);
        send_item(value_t'(-1), 1'b0);
        send_item(value_t'(0), 1'b1);

        // one full group then a short tail
        for (int i = 1; i <= 6; i++)
            send_item(value_t'(i), i == 6);

        // pass through with size zero and one
        write_group_size(GS_W'(0));
        send_item(value_t'(32'h5555_5555), 1'b0);
        send_item(value_t'(32'hAAAA_AAAA), 1'b0);
        send_item(value_t'(7), 1'b1);
        write_group_size(GS_W'(1));
        send_item(VAL_MAX, 1'b0);
        send_item(VAL_MIN, 1'b1);

        // group size lowered while three elements are buffered
        write_group_size(GS_W'(5));
        send_item(value_t'(11), 1'b0);
        send_item(value_t'(12), 1'b0);
        send_item(value_t'(13), 1'b0);
        write_group_size(GS_W'(2));
        send_item(value_t'(14), 1'b0);
        send_item(value_t'(15), 1'b1);

        // random lists, several group sizes, phases may split a list
        while (sent < RANDOM_ITEMS || list_left != 0)
        begin
            write_group_size(pick_group_size(phase));
            steady    = (phase == 3);
            phase_len = $urandom_range(20, 50);
            for (int i = 0; i < phase_len && (sent < RANDOM_ITEMS || list_left != 0); i++)
            begin
                if (list_left == 0)
                    list_left = ($urandom_range(3) == 0) ? $urandom_range(1, 3)
                                                         : $urandom_range(4, 40);
                send_item(pick_value(), list_left == 1);
                list_left--;
                sent++;
            end
            phase++;
        end
        steady = 1'b0;

        // wait for the last results, then a little longer
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        if (check_errors == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[files.f]
src/grr_pkg.sv
src/grr_in_if.sv
src/grr_out_if.sv
src/grr_cfg.sv
src/grr_ctrl.sv
src/grr_dpath.sv
src/group_reverse_reorder.sv
verif/grr_checker.sv
verif/testbench.sv
